// ===== hdl/rgbsh_pkg.sv =====
// Shared types and constants for the RGB 3x3 sharpen stream unit.
// No dependencies; imported by every module of the block except the checker.
package rgbsh_pkg;

  localparam int CHAN_W        = 8;
  localparam int PIX_W         = 3 * CHAN_W;
  localparam int WIDTH_W       = 11;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  // Cross neighborhood of one pixel, edges already replicated.
  typedef struct packed {
    pix_t up;
    pix_t left;
    pix_t centre;
    pix_t right;
    pix_t down;
  } window_t;

endpackage

// ===== hdl/rgbsh_row_bank.sv =====
// One row store bank: single write port, two read ports with registered data.
// Depends on rgbsh_pkg for the pixel type.
module rgbsh_row_bank #(
  parameter int DEPTH = rgbsh_pkg::MAX_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  rgbsh_pkg::pix_t   wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output rgbsh_pkg::pix_t   rdata_a_o,
  output rgbsh_pkg::pix_t   rdata_b_o
);
  import rgbsh_pkg::*;

  pix_t mem_q [DEPTH];
  pix_t rdata_a_q;
  pix_t rdata_b_q;

  // read-first: a read of the address being written returns the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/rgbsh_kernel.sv =====
// Cross sharpen arithmetic: 5*centre - up - down - left - right, clamped.
// Purely combinational; depends on rgbsh_pkg for the window and pixel types.
module rgbsh_kernel (
  input  rgbsh_pkg::window_t win_i,
  output rgbsh_pkg::pix_t    pix_o
);
  import rgbsh_pkg::*;

  // 12-bit two's complement covers -1020..1275
  function automatic chan_t sharpen_chan(chan_t u, chan_t l, chan_t c, chan_t r, chan_t d);
    logic [11:0] sum;
    chan_t       res;
    sum = ({4'b0, c} << 2) + {4'b0, c} - {4'b0, u} - {4'b0, l} - {4'b0, r} - {4'b0, d};
    if (sum[11]) begin
      res = '0;
    end else if (sum[10:8] != 3'b000) begin
      res = CHAN_MAX;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

  always_comb begin
    pix_o.red   = sharpen_chan(win_i.up.red, win_i.left.red, win_i.centre.red,
                               win_i.right.red, win_i.down.red);
    pix_o.green = sharpen_chan(win_i.up.green, win_i.left.green, win_i.centre.green,
                               win_i.right.green, win_i.down.green);
    pix_o.blue  = sharpen_chan(win_i.up.blue, win_i.left.blue, win_i.centre.blue,
                               win_i.right.blue, win_i.down.blue);
  end

endmodule

// ===== hdl/rgb_sharpen_3x3_stream.sv =====
// RGB 3x3 cross sharpen: one pixel per clock while the output is not stalled.
// Send image_width x image_height pixels in raster order, then image_width more
// items (any data) to flush the last row; the result for pixel (x, y) leaves on
// the request of pixel (x, y+1), so the first row gives no results and the
// drain items give the last row, with tlast on the frame's final pixel. Pad
// requests (tuser = 1) during the frame are dropped. Edge neighbors replicate
// the nearest pixel. Two row-store banks, each with two read ports, supply the
// centre, right and up taps each cycle; left is the previous centre. Pipeline
// is request -> bank read / stage 1 -> output register. Register writes restart
// the frame and must be issued only while the block is idle.
// Depends on rgbsh_pkg, rgbsh_row_bank and rgbsh_kernel.
module rgb_sharpen_3x3_stream_unit #(
  parameter int MAX_WIDTH = rgbsh_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rgbsh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbsh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input pixels
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                                s_axis_tuser,  // pad
  // sharpened pixels
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // out_red, out_green, out_blue
  output logic                                m_axis_tlast   // frame_end
);
  import rgbsh_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic [WIDTH_W-1:0]  image_width_q;
  logic [HEIGHT_W-1:0] image_height_q;
  logic [CW-1:0]       col_last;
  logic [HEIGHT_W-1:0] height_eff;

  // frame position
  logic [CW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;

  // request decode
  logic  accept, filling, take, emit, at_last_col;
  pix_t  pix_in;
  logic [CW-1:0] raddr_b;

  // bank read data
  pix_t  rd_a [2];
  pix_t  rd_b [2];

  // stage 1
  logic  s1_v_q;
  logic  s1_sel_q, s1_left_edge_q, s1_right_edge_q, s1_top_q, s1_drain_q, s1_last_q;
  pix_t  s1_down_q;
  pix_t  left_q;
  logic  s1_adv;
  window_t win;
  pix_t  res;

  // output register
  logic  out_v_q;
  logic  out_last_q;
  pix_t  out_pix_q;

  always_comb begin
    if (image_width_q == '0) begin
      col_last = '0;
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      col_last = CW'(MAX_WIDTH - 1);
    end else begin
      col_last = CW'(image_width_q - 11'd1);
    end
    height_eff = (image_height_q == '0) ? 16'd1 : image_height_q;
  end

  assign s1_adv        = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || s1_adv;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign filling     = row_q < height_eff;
  assign take        = accept && !(filling && s_axis_tuser);
  assign emit        = take && (!filling || row_q != '0);
  assign at_last_col = col_q == col_last;
  assign raddr_b     = at_last_col ? col_q : col_q + CW'(1);

  assign pix_in.red   = s_axis_tdata[7:0];
  assign pix_in.green = s_axis_tdata[15:8];
  assign pix_in.blue  = s_axis_tdata[23:16];

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (at_last_col) begin
        col_d = '0;
        row_d = filling ? row_q + 16'd1 : '0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
      col_q          <= '0;
      row_q          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i[WIDTH_W-1:0];
          col_q         <= '0;
          row_q         <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_data_i[HEIGHT_W-1:0];
          col_q          <= '0;
          row_q          <= '0;
        end
        default: ;
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // bank row_q[0] holds the row being written and the row two above;
  // the other bank holds the row just above
  for (genvar g = 0; g < 2; g++) begin : g_bank
    rgbsh_row_bank #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (take && filling && (row_q[0] == 1'(g))),
      .waddr_i   (col_q),
      .wdata_i   (pix_in),
      .re_i      (accept),
      .raddr_a_i (col_q),
      .raddr_b_i (raddr_b),
      .rdata_a_o (rd_a[g]),
      .rdata_b_o (rd_b[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && emit) begin
      s1_sel_q        <= ~row_q[0];
      s1_left_edge_q  <= col_q == '0;
      s1_right_edge_q <= at_last_col;
      s1_top_q        <= row_q == 16'd1;
      s1_drain_q      <= !filling;
      s1_last_q       <= !filling && at_last_col;
      s1_down_q       <= pix_in;
    end
  end

  always_comb begin
    win.centre = rd_a[s1_sel_q];
    win.left   = s1_left_edge_q  ? win.centre : left_q;
    win.right  = s1_right_edge_q ? win.centre : rd_b[s1_sel_q];
    win.up     = s1_top_q        ? win.centre : rd_a[~s1_sel_q];
    win.down   = s1_drain_q      ? win.centre : s1_down_q;
  end

  rgbsh_kernel u_kernel (
    .win_i (win),
    .pix_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      left_q  <= '0;
    end else if (s1_adv) begin
      out_v_q <= s1_v_q;
      if (s1_v_q) begin
        left_q <= win.centre;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_v_q) begin
      out_pix_q  <= res;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/rgbsh_checker.sv =====
// Port-level checks for the RGB 3x3 sharpen stream unit, bound to its top.
// Self-contained; watches the handshake and result ports of the top level.
module rgbsh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // with the output side taking, the pipeline always moves
  a_ready_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // an empty output register never blocks the input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind rgb_sharpen_3x3_stream_unit rgbsh_checker u_rgbsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb_rgb_sharpen_3x3_stream_unit.sv =====
// Self-checking testbench for rgb_sharpen_3x3_stream_unit: a behavioral model of
// the cross sharpen predicts every output pixel and the output stream is checked.
// Depends on rgbsh_pkg and the block's RTL.
module tb_rgb_sharpen_3x3_stream_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbsh_pkg::*;

  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int SETTLE_CYC   = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_PCT     = 14;
  localparam int PAD_PCT      = 5;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    pix_t px;
    bit   frame_end;
  } sharp_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata  = '0;  // in_red, in_green, in_blue
  logic                  s_axis_tuser  = 1'b0;  // pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;  // out_red, out_green, out_blue
  logic                  m_axis_tlast;  // frame_end

  // predictor state
  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  int                  col_cnt;
  int                  row_cnt;
  int                  drain_cnt;
  pix_t                line_mem [2*MAX_W];

  sharp_t sharp_q[$];
  bit     steady    = 1'b0;
  int     n_errors  = 0;
  int     n_items   = 0;
  int     n_checked = 0;
  int     n_frames  = 0;

  rgb_sharpen_3x3_stream_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------- predictor

  function automatic int line_slot(int y, int x);
    return ((y % 2) * MAX_W + x) % (2 * MAX_W);
  endfunction

  function automatic chan_t sharpen_chan(chan_t c, chan_t u, chan_t d, chan_t l, chan_t r);
    int acc;
    acc = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
    if (acc < 0) acc = 0;
    if (acc > int'(CHAN_MAX)) acc = int'(CHAN_MAX);
    return chan_t'(acc);
  endfunction

  function automatic pix_t sharpen_at(int y, int x, int w, pix_t down);
    pix_t c, l, r, u, res;
    c = line_mem[line_slot(y, x)];
    l = line_mem[line_slot(y, (x > 0) ? x - 1 : x)];
    r = (x + 1 < w) ? line_mem[line_slot(y, x + 1)] : c;
    u = (y > 0) ? line_mem[line_slot(y - 1, x)] : c;
    res.red   = sharpen_chan(c.red, u.red, down.red, l.red, r.red);
    res.green = sharpen_chan(c.green, u.green, down.green, l.green, r.green);
    res.blue  = sharpen_chan(c.blue, u.blue, down.blue, l.blue, r.blue);
    return res;
  endfunction

  // -1: request ignored, 0: no pixel out, 1: one pixel out in res
  function automatic int predict_sharpen(bit pad, pix_t px, output sharp_t res);
    int w, h, n;
    bit fin;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    n = 0;
    res.px = '0;
    res.frame_end = 1'b0;
    if (col_cnt >= w) col_cnt = 0;
    if (drain_cnt >= w) drain_cnt = 0;
    if (row_cnt > h) row_cnt = h;
    if (row_cnt < h) begin
      if (pad) return -1;
      if (row_cnt > 0) begin
        res.px = sharpen_at(row_cnt - 1, col_cnt, w, px);
        n = 1;
      end
      line_mem[line_slot(row_cnt, col_cnt)] = px;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      return n;
    end
    // draining: bottom row, down tap is the pixel itself
    fin = (drain_cnt + 1 >= w);
    res.px = sharpen_at(h - 1, drain_cnt, w, line_mem[line_slot(h - 1, drain_cnt)]);
    res.frame_end = fin;
    drain_cnt++;
    if (fin) begin
      drain_cnt = 0;
      row_cnt = 0;
      col_cnt = 0;
    end
    return 1;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) cfg_width = data[WIDTH_W-1:0];
    else if (idx == REG_IMAGE_HEIGHT) cfg_height = data[HEIGHT_W-1:0];
    else return;
    col_cnt = 0;
    row_cnt = 0;
    drain_cnt = 0;
  endfunction

  function automatic pix_t rand_pix();
    pix_t p;
    p = pix_t'(24'($urandom));
    // lean on the rails so both clamps get hit often
    if ($urandom_range(4) == 0) p.red = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(4) == 0) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(4) == 0) p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin
    sharp_t exp_px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (sharp_q.size() == 0) begin
        $error("unexpected pixel out: data %h last %b", m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        exp_px = sharp_q.pop_front();
        if (m_axis_tdata[7:0] !== exp_px.px.red) begin
          $error("out_red: expected %0d, got %0d", exp_px.px.red, m_axis_tdata[7:0]);
          n_errors++;
        end
        if (m_axis_tdata[15:8] !== exp_px.px.green) begin
          $error("out_green: expected %0d, got %0d", exp_px.px.green, m_axis_tdata[15:8]);
          n_errors++;
        end
        if (m_axis_tdata[23:16] !== exp_px.px.blue) begin
          $error("out_blue: expected %0d, got %0d", exp_px.px.blue, m_axis_tdata[23:16]);
          n_errors++;
        end
        if (m_axis_tlast !== exp_px.frame_end) begin
          $error("frame_end: expected %0d, got %0d", exp_px.frame_end, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall = 0;
      else stall++;
    end
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // ------------------------------------------------------------ stimulus side

  task automatic send_item(bit pad, pix_t px);
    sharp_t res;
    int kind;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.blue, px.green, px.red};
    s_axis_tuser  <= pad;
    do @(posedge clk_i); while (!s_axis_tready);
    kind = predict_sharpen(pad, px, res);
    if (kind >= 0) n_items++;
    if (kind > 0) sharp_q.push_back(res);
  endtask

  task automatic hold_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sharp_q.size() != 0);
  endtask

  // first-row pixels and pads give nothing out, so give the pipeline time to empty
  task automatic settle_block();
    hold_for_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_config(idx, data);
    @(posedge clk_i);
  endtask

  // w, h are the effective sizes; fewer than w*h pixels leaves the frame unfinished
  task automatic send_frame(int w, int h, int pixels, bit pressure);
    int i;
    for (i = 0; i < pixels; i++) begin
      if ($urandom_range(99) < PAD_PCT) send_item(1'b1, rand_pix());
      send_item(1'b0, rand_pix());
      if (pressure && i == pixels / 2) hold_for_results();
    end
    if (pixels == w * h) begin
      for (i = 0; i < w; i++) send_item(1'($urandom_range(1)), rand_pix());
      n_frames++;
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_extreme_frame();
    int x, y;
    pix_t px;
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_item(1'b1, '1);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 3; x++) begin
        px.red   = ((x + y) % 2 != 0) ? 8'hFF : 8'h00;
        px.green = ~px.red;
        px.blue  = (x == 1 && y == 1) ? 8'hFF : 8'h00;
        send_item(1'b0, px);
        if (y == 1 && x == 0) send_item(1'b1, '0);
      end
    end
    // drain requests: pad bit and data are don't-care
    send_item(1'b1, '1);
    send_item(1'b0, '1);
    send_item(1'b1, '0);
    n_frames++;
    settle_block();
  endtask

  task automatic test_degenerate_sizes();
    write_reg(REG_IMAGE_WIDTH, 16'hF800);  // width field 0, upper bits ignored
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    send_frame(1, 1, 1, 1'b0);
    settle_block();
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_frame(1, 2, 2, 1'b0);
    settle_block();
  endtask

  task automatic test_unused_index();
    int i;
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    for (i = 0; i < 4; i++) send_item(1'b0, rand_pix());
    settle_block();
    // frame must carry on where it stopped
    write_reg(REG_UNUSED_A, 16'hFFFF);
    write_reg(REG_UNUSED_B, 16'h0000);
    for (i = 0; i < 2; i++) send_item(1'b0, rand_pix());
    for (i = 0; i < 3; i++) send_item(1'($urandom_range(1)), rand_pix());
    n_frames++;
    settle_block();
  endtask

  task automatic test_restart_on_write();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_frame(4, 3, 6, 1'b0);
    settle_block();
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_frame(4, 3, 12, 1'b0);
    settle_block();
  endtask

  task automatic test_random_frames();
    int w, h, full, pixels, start, frame_no;
    bit pressure;
    start = n_items;
    frame_no = 0;
    while (n_items - start < RANDOM_ITEMS) begin
      // a run of frames with neither side idling
      steady = (frame_no >= 6 && frame_no < 14);
      w = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      write_reg(REG_IMAGE_WIDTH, {5'($urandom_range(31)), 11'(w)});
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      full = w * h;
      // some frames are cut short and restarted by the next register write
      pixels = ($urandom_range(7) == 0) ? $urandom_range(full - 1) : full;
      pressure = (frame_no % 5 == 2);
      send_frame(w, h, pixels, pressure);
      settle_block();
      frame_no++;
    end
    steady = 1'b0;
  endtask

  // top of a frame only; the next register write restarts it
  task automatic test_widest_row();
    write_reg(REG_IMAGE_WIDTH, 16'h07FF);  // clamps to the row store size
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_frame(MAX_W, 2, 48, 1'b0);
    settle_block();
  endtask

  task automatic test_tallest_column();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    send_frame(4, 65535, 24, 1'b0);
    settle_block();
  endtask

  initial begin
    cfg_width  = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    col_cnt    = 0;
    row_cnt    = 0;
    drain_cnt  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_frame();
    test_degenerate_sizes();
    test_unused_index();
    test_restart_on_write();
    test_random_frames();
    test_widest_row();
    test_tallest_column();

    $display("Covered %0d full frames of widths 1 to 64, cut and restarted frames,",
             n_frames);
    $display("pads, drains, size limits, unused-index writes: %0d requests, %0d checked, %0d errors",
             n_items, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rgbsh_pkg.sv
hdl/rgbsh_row_bank.sv
hdl/rgbsh_kernel.sv
hdl/rgb_sharpen_3x3_stream.sv
hdl/rgbsh_checker.sv
tb/sv/tb_rgb_sharpen_3x3_stream_unit.sv
